[hw/rtl/line_follow_steer_speed_control_defines.svh]
// Assertion macros used by the checker file.
`ifndef LINE_FOLLOW_STEER_SPEED_CONTROL_DEFINES_SVH
`define LINE_FOLLOW_STEER_SPEED_CONTROL_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define LFSSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define LFSSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lfssc_pkg.sv]
`default_nettype none

package lfssc_pkg;

    // field widths
    localparam int LINE_ERROR_W = 16;
    localparam int GYRO_W       = 16;
    localparam int SPEED_W      = 15;
    localparam int GAIN_W       = 16;
    localparam int DRIVE_W      = 17;
    localparam int CORR_W       = 13;

    // stream packing
    localparam int S_TDATA_W       = 48;
    localparam int S_TUSER_W       = 2;
    localparam int M_TDATA_W       = 64;
    localparam int S_ERR_LSB       = 0;
    localparam int S_GYRO_LSB      = 16;
    localparam int S_BASE_LSB      = 32;
    localparam int S_USER_STRAIGHT = 0;
    localparam int S_USER_RUN      = 1;
    localparam int M_LEFT_LSB      = 0;
    localparam int M_RIGHT_LSB     = 17;
    localparam int M_TARGET_LSB    = 34;
    localparam int M_CORR_LSB      = 49;
    localparam int M_PAD_W         = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SPEED,
        REG_MIN_SPEED,
        REG_MAX_DEV,
        REG_GAIN_P,
        REG_GAIN_P_SQ,
        REG_GAIN_D,
        REG_GAIN_GYRO
    } cfg_reg_t;

    localparam logic [SPEED_W-1:0]       MAX_SPEED_RST = 15'd1400;
    localparam logic [SPEED_W-1:0]       MIN_SPEED_RST = 15'd1000;
    localparam logic [SPEED_W-1:0]       MAX_DEV_RST   = 15'd2048;
    localparam logic signed [GAIN_W-1:0] GAIN_P_RST    = 16'sd2048;
    localparam logic signed [GAIN_W-1:0] GAIN_P_SQ_RST = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST    = 16'sd205;
    localparam logic signed [GAIN_W-1:0] GAIN_GYRO_RST = -16'sd166;

    // internal datapath widths
    localparam int E40_W      = LINE_ERROR_W + 6;  // line error times 40
    localparam int ERR_W      = 20;                // clamped steering error
    localparam int AERR_W     = 19;                // its magnitude
    localparam int MUL_W      = 21;                // shared multiplier operands
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 56;                // PD sum at scale 2^-24
    localparam int SC_W       = 22;                // slope halves times |error|
    localparam int SC5_W      = SC_W + 3;
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;
    localparam int QUO_W      = 16;
    localparam int SLOPE_W    = 7;

    // constants of the control law
    localparam int ERR_LIMIT   = 512000;   // 2000.0 in Q12.8
    localparam int CORR_LIMIT  = 2300;
    localparam int CORR_SHIFT  = 24;
    localparam int SAT_NUM     = 4;        // 0.8 = 4/5
    localparam int SAT_DEN     = 5;
    localparam int BAND0_LIMIT = 26;       // c < 0.1 in Q8.8 (10*c < 256)
    localparam int BAND1_LIMIT = 128;      // c < 0.5
    localparam int BAND2_LIMIT = 256;      // c < 1.0

    localparam logic signed [ACC_W-1:0] ACC_LIMIT  = ACC_W'(CORR_LIMIT) <<< CORR_SHIFT;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = (ACC_W'(1) <<< CORR_SHIFT) - ACC_W'(1);

    // slopes held in halves, one per band
    localparam logic [SLOPE_W-1:0] SLOPE_STRAIGHT [4] = '{7'd30, 7'd6, 7'd8, 7'd3};
    localparam logic [SLOPE_W-1:0] SLOPE_CURVE    [4] = '{7'd70, 7'd10, 7'd16, 7'd5};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CURVE_MUL,
        ST_CURVE_CMP,
        ST_REDUCE_MUL,
        ST_DIV_START,
        ST_PD_GP,
        ST_PD_GQ,
        ST_PD_QLO,
        ST_PD_QHI,
        ST_PD_D,
        ST_PD_G,
        ST_PD_END,
        ST_CLAMP,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    function automatic logic [SLOPE_W-1:0] slope_halves(
        input logic [LINE_ERROR_W-1:0] c,
        input logic                    straight
    );
        logic [1:0] band;
        if (c < LINE_ERROR_W'(BAND0_LIMIT)) begin
            band = 2'd0;
        end else if (c < LINE_ERROR_W'(BAND1_LIMIT)) begin
            band = 2'd1;
        end else if (c < LINE_ERROR_W'(BAND2_LIMIT)) begin
            band = 2'd2;
        end else begin
            band = 2'd3;
        end
        return straight ? SLOPE_STRAIGHT[band] : SLOPE_CURVE[band];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lfssc_div.sv]
`default_nettype none

// Restoring divider, one quotient bit a cycle.
// Dividend must stay below divisor * 2^QUO_W.
module lfssc_div
    import lfssc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [QUO_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(QUO_W);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dvs_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic                  take;

    assign take     = rem_reg >= dvs_reg;
    assign rem_next = take ? rem_reg - dvs_reg : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUO_W - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dvs_reg <= DIVIDEND_W'({divisor, {(QUO_W-1){1'b0}}});
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[hw/rtl/line_follow_steer_speed_control.sv]
`default_nettype none

// Channel  Direction  Handshake           Payload
// s_       in         s_tvalid/s_tready   tdata: line_error, gyro_rate, base_speed
//                                         tuser: straight_mode, run_enable
// m_       out        m_tvalid/m_tready   tdata: left_drive, right_drive,
//                                         target_speed, steer_correction
// cfg_     in         cfg_we              cfg_index, cfg_wdata (no read-back)
//
// One item at a time; the PD products are worked through the one shared 21x21
// multiplier while the 16-step divider runs.
// Reset (aresetn, synchronous) loads the register defaults and clears the
// stored steering error. A result waiting in the output register does not
// stop the next item being taken; the block only holds in its last step if
// the previous result has still not left.
module line_follow_steer_speed_control
    import lfssc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] line_error, [31:16] gyro_rate, [46:32] base_speed, [47] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] straight_mode, [1] run_enable
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [16:0] left_drive, [33:17] right_drive, [48:34] target_speed,
    // [61:49] steer_correction, [63:62] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    state_t state_reg, state_next;

    // configuration registers
    logic [SPEED_W-1:0]       max_speed_reg, min_speed_reg, max_dev_reg;
    logic signed [GAIN_W-1:0] gain_p_reg, gain_p_sq_reg, gain_d_reg, gain_gyro_reg;

    // captured item
    logic [LINE_ERROR_W-1:0]  c_reg;
    logic                     straight_reg, run_reg;
    logic signed [GYRO_W-1:0] gyro_reg;
    logic [SPEED_W-1:0]       base_reg;
    logic signed [ERR_W-1:0]  err_reg, last_err_reg;
    logic [AERR_W-1:0]        aerr_reg;

    // shared unit and working state
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-5:0] q_reg;      // err * gain_p_square, 38 bits
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     sat_reg, neg_reg;
    logic signed [CORR_W-1:0] corr_reg, corr_next;

    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;

    // control
    logic in_accept, mul_en, acc_en, div_start, out_load;
    logic div_busy;
    logic [QUO_W-1:0] div_quo;

    assign in_accept = s_tvalid && s_tready;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (s_tvalid) state_next = ST_CURVE_MUL;
            ST_CURVE_MUL:  state_next = ST_CURVE_CMP;
            ST_CURVE_CMP:  state_next = ST_REDUCE_MUL;
            ST_REDUCE_MUL: state_next = ST_DIV_START;
            ST_DIV_START:  state_next = ST_PD_GP;
            ST_PD_GP:      state_next = ST_PD_GQ;
            ST_PD_GQ:      state_next = ST_PD_QLO;
            ST_PD_QLO:     state_next = ST_PD_QHI;
            ST_PD_QHI:     state_next = ST_PD_D;
            ST_PD_D:       state_next = ST_PD_G;
            ST_PD_G:       state_next = ST_PD_END;
            ST_PD_END:     state_next = ST_CLAMP;
            ST_CLAMP:      state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:   if (!div_busy) state_next = ST_FINISH;
            ST_FINISH:     if (out_load) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        mul_en    = state_reg inside {ST_CURVE_MUL, ST_REDUCE_MUL, ST_PD_GP, ST_PD_GQ,
                                      ST_PD_QLO, ST_PD_QHI, ST_PD_D, ST_PD_G};
        acc_en    = state_reg inside {ST_PD_GQ, ST_PD_QHI, ST_PD_D, ST_PD_G, ST_PD_END};
        div_start = (state_reg == ST_DIV_START);
        out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= MAX_SPEED_RST;
            min_speed_reg <= MIN_SPEED_RST;
            max_dev_reg   <= MAX_DEV_RST;
            gain_p_reg    <= GAIN_P_RST;
            gain_p_sq_reg <= GAIN_P_SQ_RST;
            gain_d_reg    <= GAIN_D_RST;
            gain_gyro_reg <= GAIN_GYRO_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAX_SPEED: max_speed_reg <= cfg_wdata[SPEED_W-1:0];
                REG_MIN_SPEED: min_speed_reg <= cfg_wdata[SPEED_W-1:0];
                REG_MAX_DEV:   max_dev_reg   <= cfg_wdata[SPEED_W-1:0];
                REG_GAIN_P:    gain_p_reg    <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_P_SQ: gain_p_sq_reg <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_D:    gain_d_reg    <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_GYRO: gain_gyro_reg <= $signed(cfg_wdata[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    // ---------------- item capture ----------------
    // |error| for the speed schedule, error*40 limited to +-2000.0 for steering
    logic signed [LINE_ERROR_W-1:0] in_err;
    logic [LINE_ERROR_W-1:0]        in_c;
    logic signed [E40_W-1:0]        in_e_ext, in_e40;
    logic signed [ERR_W-1:0]        in_err_sat, in_err_neg;
    logic [AERR_W-1:0]              in_aerr;

    assign in_err   = $signed(s_tdata[S_ERR_LSB +: LINE_ERROR_W]);
    assign in_c     = in_err[LINE_ERROR_W-1] ? (~s_tdata[S_ERR_LSB +: LINE_ERROR_W] + 1'b1)
                                             : s_tdata[S_ERR_LSB +: LINE_ERROR_W];
    assign in_e_ext = E40_W'(in_err);
    assign in_e40   = (in_e_ext <<< 5) + (in_e_ext <<< 3);

    always_comb begin
        if (in_e40 > E40_W'(ERR_LIMIT)) begin
            in_err_sat = ERR_W'(ERR_LIMIT);
        end else if (in_e40 < E40_W'(-ERR_LIMIT)) begin
            in_err_sat = ERR_W'(-ERR_LIMIT);
        end else begin
            in_err_sat = in_e40[ERR_W-1:0];
        end
    end

    assign in_err_neg = -in_err_sat;
    assign in_aerr    = in_err_sat[ERR_W-1] ? in_err_neg[AERR_W-1:0] : in_err_sat[AERR_W-1:0];

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            c_reg        <= in_c;
            straight_reg <= s_tuser[S_USER_STRAIGHT];
            run_reg      <= s_tuser[S_USER_RUN];
            gyro_reg     <= $signed(s_tdata[S_GYRO_LSB +: GYRO_W]);
            base_reg     <= s_tdata[S_BASE_LSB +: SPEED_W];
            err_reg      <= in_err_sat;
            aerr_reg     <= in_aerr;
        end
    end

    // ---------------- shared multiplier ----------------
    logic [SPEED_W-1:0]        md;          // zero deviation counts as one
    logic signed [SPEED_W:0]   delta;       // max - min, may go negative
    logic signed [MUL_W-1:0]   ediff;
    logic signed [MUL_W-1:0]   mul_a, mul_b;

    assign md    = (max_dev_reg == '0) ? SPEED_W'(1) : max_dev_reg;
    assign delta = $signed({1'b0, max_speed_reg}) - $signed({1'b0, min_speed_reg});
    assign ediff = MUL_W'(err_reg) - MUL_W'(last_err_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_CURVE_MUL: begin
                mul_a = MUL_W'(slope_halves(c_reg, straight_reg));
                mul_b = MUL_W'(c_reg);
            end
            ST_REDUCE_MUL: begin
                // below the 0.8 knee the slope product is under 2^16
                mul_a = MUL_W'(delta);
                mul_b = sat_reg ? MUL_W'(SAT_NUM) : MUL_W'(prod_reg[DIVISOR_W-1:0]);
            end
            ST_PD_GP: begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(gain_p_reg);
            end
            ST_PD_GQ: begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(gain_p_sq_reg);
            end
            ST_PD_QLO: begin
                // low 18 bits of err*gq, unsigned, times |err|
                mul_a = MUL_W'(prod_reg[17:0]);
                mul_b = MUL_W'(aerr_reg);
            end
            ST_PD_QHI: begin
                mul_a = MUL_W'($signed(q_reg[PROD_W-5:18]));
                mul_b = MUL_W'(aerr_reg);
            end
            ST_PD_D: begin
                mul_a = ediff;
                mul_b = MUL_W'(gain_d_reg);
            end
            ST_PD_G: begin
                mul_a = MUL_W'(gyro_reg);
                mul_b = MUL_W'(gain_gyro_reg);
            end
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_PD_QLO) begin
            q_reg <= prod_reg[PROD_W-5:0];
        end
    end

    // ---------------- curvature knee ----------------
    logic [SC_W-1:0]  sc;
    logic [SC5_W-1:0] sc5, md8;

    assign sc  = prod_reg[SC_W-1:0];
    assign sc5 = (SC5_W'(sc) << 2) + SC5_W'(sc);
    assign md8 = SC5_W'({md, 3'b000});

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CURVE_CMP) begin
            sat_reg <= (sc5 >= md8);
        end
        if (div_start) begin
            neg_reg <= prod_reg[PROD_W-1];
        end
    end

    // ---------------- divider ----------------
    logic signed [PROD_W-1:0] prod_neg;
    logic [DIVIDEND_W-1:0]    div_dividend;
    logic [DIVISOR_W-1:0]     div_divisor;

    assign prod_neg     = -prod_reg;
    assign div_dividend = prod_reg[PROD_W-1] ? prod_neg[DIVIDEND_W-1:0]
                                             : prod_reg[DIVIDEND_W-1:0];
    assign div_divisor  = sat_reg ? DIVISOR_W'(SAT_DEN) : {md, 1'b0};

    lfssc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // ---------------- PD accumulator ----------------
    logic signed [ACC_W-1:0] prod_ext, addend, acc_base;

    assign prod_ext = ACC_W'(prod_reg);

    always_comb begin
        acc_base = acc_reg;
        addend   = prod_ext;
        case (state_reg)
            ST_PD_GQ: begin
                acc_base = '0;
                addend   = prod_ext <<< 8;       // err * gp
            end
            ST_PD_QHI: addend = prod_ext;        // low part of err*|err|*gq
            ST_PD_D:   addend = prod_ext <<< 18; // high part of err*|err|*gq
            ST_PD_G:   addend = prod_ext <<< 8;  // error difference * gd
            ST_PD_END: addend = prod_ext <<< 16; // gyro * gg
            default: ;
        endcase
    end

    assign acc_next = acc_base + addend;

    always_ff @(posedge aclk) begin
        if (acc_en) begin
            acc_reg <= acc_next;
        end
    end

    // clamp to +-2300 and drop the 2^-24 scale, truncating toward zero
    logic signed [ACC_W-1:0] acc_biased, acc_shifted;

    assign acc_biased  = acc_reg[ACC_W-1] ? acc_reg + ROUND_BIAS : acc_reg;
    assign acc_shifted = acc_biased >>> CORR_SHIFT;

    always_comb begin
        if (acc_reg > ACC_LIMIT) begin
            corr_next = CORR_W'(CORR_LIMIT);
        end else if (acc_reg < -ACC_LIMIT) begin
            corr_next = CORR_W'(-CORR_LIMIT);
        end else begin
            corr_next = acc_shifted[CORR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLAMP) begin
            corr_reg <= corr_next;
        end
    end

    // ---------------- result ----------------
    logic signed [SPEED_W+1:0]  reduce;
    logic signed [SPEED_W+2:0]  t_raw, t_lo, mn_x, mx_x;
    logic [SPEED_W-1:0]         target;
    logic signed [DRIVE_W-1:0]  base_x, corr_x, left, right;

    assign reduce = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign mn_x   = $signed({3'b000, min_speed_reg});
    assign mx_x   = $signed({3'b000, max_speed_reg});
    assign t_raw  = mx_x - (SPEED_W+3)'(reduce);
    assign t_lo   = (t_raw < mn_x) ? mn_x : t_raw;
    assign target = (t_lo > mx_x) ? max_speed_reg : t_lo[SPEED_W-1:0];

    assign base_x = $signed({2'b00, base_reg});
    assign corr_x = DRIVE_W'(corr_reg);
    assign left   = run_reg ? base_x + corr_x : '0;
    assign right  = run_reg ? base_x - corr_x : '0;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {{M_PAD_W{1'b0}}, corr_reg, target, right, left};
        end
    end

    // stored steering error advances on every item, run flag or not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            last_err_reg <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg  <= 1'b1;
                last_err_reg <= err_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

[hw/rtl/lfssc_checker.sv]
`default_nettype none

`include "line_follow_steer_speed_control_defines.svh"

module lfssc_checker
    import lfssc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic signed [CORR_W-1:0]  corr;
    logic [DRIVE_W-1:0]        left, right, drv_diff, corr_x2;
    logic                      corr_ok, drv_zero;

    assign corr     = $signed(m_tdata[M_CORR_LSB +: CORR_W]);
    assign left     = m_tdata[M_LEFT_LSB +: DRIVE_W];
    assign right    = m_tdata[M_RIGHT_LSB +: DRIVE_W];
    assign drv_diff = left - right;
    assign corr_x2  = DRIVE_W'(corr) << 1;
    assign corr_ok  = (corr <= CORR_LIMIT) && (corr >= -CORR_LIMIT);
    assign drv_zero = (left == '0) && (right == '0);

    // one item in flight: the block drops ready straight after taking one
    `LFSSC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken early")

    `LFSSC_ASSERT_IMPL(a_corr_range, m_tvalid, corr_ok, "steer correction out of range")

    // drives are either both off or split by twice the correction
    `LFSSC_ASSERT_IMPL(a_drive_split, m_tvalid, drv_zero || (drv_diff == corr_x2), "drive mismatch")

    `LFSSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result lost")

endmodule

bind line_follow_steer_speed_control lfssc_checker u_lfssc_checker (.*);

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

// Bench for the line-follow steering and speed block.
// A driver walks a short table of hand-picked items, then ten phases of random
// items, each phase under its own register settings. Every accepted item is run
// through a local model of the control law and the predicted drive result is
// queued; a watcher pops that queue as results leave the block and compares
// field by field.
module tb;
    import lfssc_pkg::*;

    localparam int     PHASES        = 10;
    localparam int     PHASE_ITEMS   = 115;
    localparam int     IDLE_PCT      = 37;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     SETTLE_CYCLES = 30;
    localparam longint CORR_SCALE    = 64'sd16777216;   // PD sum is held at 2^-24
    localparam longint CORR_SAT      = 64'sd2300 * CORR_SCALE;
    localparam longint STEER_SAT     = 64'sd512000;     // 2000.0 in Q12.8

    // One control tick as the sender sees it.
    typedef struct packed {
        logic signed [LINE_ERROR_W-1:0] line_err;
        logic                           straight;
        logic signed [GYRO_W-1:0]       gyro;
        logic [SPEED_W-1:0]             base;
        logic                           run;
    } ctl_item_t;

    // One drive result, at the port widths.
    typedef struct packed {
        logic [DRIVE_W-1:0] left_drv;
        logic [DRIVE_W-1:0] right_drv;
        logic [SPEED_W-1:0] tgt_speed;
        logic [CORR_W-1:0]  steer_corr;
    } drive_result_t;

    // Directed row: the stimulus, and a typed-in result where it is obvious.
    typedef struct packed {
        ctl_item_t     stim;
        logic          known;
        drive_result_t want;
    } dir_row_t;

    // Only the first three rows carry a hand-worked result: reset settings,
    // zero error, then full-scale errors of either sign (both saturate the PD
    // term and the curvature ratio). Band edges, ratio saturation edges, the
    // steering error limit, gyro extremes and a cleared run flag follow.
    localparam dir_row_t DIRECTED [22] = '{
        '{'{16'sd0,      1'b0, 16'sd0,      15'd1000,  1'b1}, 1'b1,
          '{17'd1000, 17'd1000, 15'd1400, 13'd0}},
        '{'{16'sd32767,  1'b0, 16'sd0,      15'd32767, 1'b1}, 1'b1,
          '{17'd35067, 17'd30467, 15'd1080, 13'd2300}},
        '{'{-16'sd32768, 1'b1, 16'sd0,      15'd0,     1'b1}, 1'b1,
          '{-17'sd2300, 17'd2300, 15'd1080, -13'sd2300}},
        '{'{16'sd0,      1'b0, 16'sd0,      15'd500,   1'b0}, 1'b0, '0},
        '{'{16'sd25,     1'b0, 16'sd0,      15'd1200,  1'b1}, 1'b0, '0},
        '{'{16'sd26,     1'b0, 16'sd0,      15'd1200,  1'b1}, 1'b0, '0},
        '{'{-16'sd25,    1'b1, 16'sd100,    15'd1200,  1'b1}, 1'b0, '0},
        '{'{-16'sd26,    1'b1, -16'sd100,   15'd1200,  1'b1}, 1'b0, '0},
        '{'{16'sd127,    1'b0, 16'sd0,      15'd1500,  1'b1}, 1'b0, '0},
        '{'{16'sd128,    1'b0, 16'sd0,      15'd1500,  1'b1}, 1'b0, '0},
        '{'{16'sd255,    1'b1, 16'sd0,      15'd1500,  1'b1}, 1'b0, '0},
        '{'{-16'sd256,   1'b1, 16'sd0,      15'd1500,  1'b1}, 1'b0, '0},
        '{'{16'sd655,    1'b0, 16'sd0,      15'd1500,  1'b1}, 1'b0, '0},
        '{'{-16'sd656,   1'b0, 16'sd0,      15'd1500,  1'b1}, 1'b0, '0},
        '{'{16'sd1092,   1'b1, 16'sd0,      15'd1500,  1'b1}, 1'b0, '0},
        '{'{-16'sd1093,  1'b1, 16'sd0,      15'd1500,  1'b1}, 1'b0, '0},
        '{'{16'sd0,      1'b0, 16'sd32767,  15'd2000,  1'b1}, 1'b0, '0},
        '{'{16'sd0,      1'b1, -16'sd32768, 15'd2000,  1'b1}, 1'b0, '0},
        '{'{16'sd12800,  1'b0, 16'sd0,      15'd1000,  1'b1}, 1'b0, '0},
        '{'{-16'sd12801, 1'b1, 16'sd0,      15'd1000,  1'b0}, 1'b0, '0},
        '{'{16'sd3,      1'b0, -16'sd1,     15'd0,     1'b1}, 1'b0, '0},
        '{'{-16'sd1,     1'b1, 16'sd1,      15'd32767, 1'b0}, 1'b0, '0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Local copy of the register file and of the stored steering error.
    logic [SPEED_W-1:0]       set_max_spd = MAX_SPEED_RST;
    logic [SPEED_W-1:0]       set_min_spd = MIN_SPEED_RST;
    logic [SPEED_W-1:0]       set_max_dev = MAX_DEV_RST;
    logic signed [GAIN_W-1:0] set_gp      = GAIN_P_RST;
    logic signed [GAIN_W-1:0] set_gq      = GAIN_P_SQ_RST;
    logic signed [GAIN_W-1:0] set_gd      = GAIN_D_RST;
    logic signed [GAIN_W-1:0] set_gg      = GAIN_GYRO_RST;
    longint                   prev_steer_err = 0;

    drive_result_t pending_drives[$];
    int unsigned   mismatches = 0;
    int unsigned   results_seen = 0;

    // Flags from the driver to the receiver; only ever written with NBAs.
    logic          steady_flow = 1'b0;
    int unsigned   holds_asked = 0;
    int unsigned   holds_served = 0;
    int unsigned   hold_left = 0;

    line_follow_steer_speed_control i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("line_follow_steer_speed_control verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Curvature speed schedule and PD steering law for one tick; also moves
    // the stored steering error on, run flag or not.
    function automatic drive_result_t predict_drive(input ctl_item_t it);
        longint e, c, s2, mx, mn, md, delta, reduce, tgt;
        longint err, aerr, gyro, gp, gq, gd, gg, sum, corr, lft, rgt;
        drive_result_t res;
        e    = $signed(it.line_err);
        gyro = $signed(it.gyro);
        c    = (e < 0) ? -e : e;
        // slopes in halves: straight 15, 3, 4, 1.5; curve 35, 5, 8, 2.5
        if (c * 10 < 256) begin
            s2 = it.straight ? 30 : 70;
        end else if (c < 128) begin
            s2 = it.straight ? 6 : 10;
        end else if (c < 256) begin
            s2 = it.straight ? 8 : 16;
        end else begin
            s2 = it.straight ? 3 : 5;
        end
        mx    = set_max_spd;
        mn    = set_min_spd;
        md    = (set_max_dev == '0) ? 1 : set_max_dev;
        delta = mx - mn;
        // ratio capped at 0.8
        if (5 * s2 * c >= 8 * md) begin
            reduce = delta * 4 / 5;
        end else begin
            reduce = delta * s2 * c / (2 * md);
        end
        tgt = mx - reduce;
        if (tgt < mn) tgt = mn;
        if (tgt > mx) tgt = mx;

        err = e * 40;
        if (err > STEER_SAT) err = STEER_SAT;
        else if (err < -STEER_SAT) err = -STEER_SAT;
        aerr = (err < 0) ? -err : err;
        gp   = $signed(set_gp);
        gq   = $signed(set_gq);
        gd   = $signed(set_gd);
        gg   = $signed(set_gg);
        sum  = err * gp * 256 + err * aerr * gq
             + (err - prev_steer_err) * gd * 256 + gyro * gg * 65536;
        if (sum > CORR_SAT) sum = CORR_SAT;
        else if (sum < -CORR_SAT) sum = -CORR_SAT;
        corr = sum / CORR_SCALE;            // truncates toward zero
        prev_steer_err = err;

        lft = it.run ? it.base + corr : 0;
        rgt = it.run ? it.base - corr : 0;
        res.left_drv   = lft[DRIVE_W-1:0];
        res.right_drv  = rgt[DRIVE_W-1:0];
        res.tgt_speed  = tgt[SPEED_W-1:0];
        res.steer_corr = corr[CORR_W-1:0];
        return res;
    endfunction

    // Mostly errors around the slope bands, some wide ones, some full scale.
    function automatic ctl_item_t random_item();
        ctl_item_t it;
        int        v;
        int        pick;
        pick = $urandom_range(9);
        if (pick <= 5) begin
            v = $urandom_range(300);
        end else if (pick <= 7) begin
            v = $urandom_range(2000);
        end else if (pick == 8) begin
            v = $urandom_range(32767);
        end else begin
            case ($urandom_range(5))
                0: v = 25;
                1: v = 26;
                2: v = 127;
                3: v = 128;
                4: v = 256;
                default: v = 32768;
            endcase
        end
        if ($urandom_range(1)) v = -v;
        it.line_err = LINE_ERROR_W'(v);
        it.straight = $urandom_range(1);
        v = $urandom_range(1) ? $urandom_range(500) : $urandom_range(32768);
        if ($urandom_range(1)) v = -v;
        it.gyro = GYRO_W'(v);
        it.base = ($urandom_range(9) < 7) ? SPEED_W'($urandom_range(3000, 500))
                                          : SPEED_W'($urandom);
        it.run  = ($urandom_range(99) < 85);
        return it;
    endfunction

    // Offer one item, possibly after a few idle cycles; returns at the edge
    // that took it, leaving tvalid high so a following item keeps it up.
    task automatic offer_item(input ctl_item_t it, input logic known,
                              input drive_result_t want);
        drive_result_t         predicted;
        logic [S_TUSER_W-1:0]  user_bits;
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        user_bits                  = '0;
        user_bits[S_USER_STRAIGHT] = it.straight;
        user_bits[S_USER_RUN]      = it.run;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it.base, it.gyro, it.line_err};
        s_tuser  <= user_bits;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_drive(it);
        pending_drives.push_back(known ? want : predicted);
    endtask

    task automatic wait_drained();
        while (pending_drives.size() != 0) @(posedge aclk);
    endtask

    // One register write; keeps the local copy in step. cfg_we is lowered by
    // the caller once the whole set is written.
    task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_MAX_SPEED: set_max_spd = val[SPEED_W-1:0];
            REG_MIN_SPEED: set_min_spd = val[SPEED_W-1:0];
            REG_MAX_DEV:   set_max_dev = val[SPEED_W-1:0];
            REG_GAIN_P:    set_gp      = val;
            REG_GAIN_P_SQ: set_gq      = val;
            REG_GAIN_D:    set_gd      = val;
            REG_GAIN_GYRO: set_gg      = val;
            default: ;
        endcase
    endtask

    // Register set for each phase after the first (which runs on reset values).
    task automatic load_settings(input int ph);
        logic [CFG_DATA_W-1:0] mx, mn, dv, gp, gq, gd, gg;
        // random defaults, overridden by the fixed phases below
        mx = CFG_DATA_W'($urandom_range(3000, 600));
        mn = CFG_DATA_W'($urandom_range(2000));
        dv = CFG_DATA_W'($urandom_range(4096, 64));
        gp = CFG_DATA_W'(int'($urandom_range(8000)) - 4000);
        gq = CFG_DATA_W'(int'($urandom_range(60)) - 30);
        gd = CFG_DATA_W'(int'($urandom_range(2000)) - 1000);
        gg = CFG_DATA_W'(int'($urandom_range(2000)) - 1000);
        case (ph)
            1: begin    // widest speed span, smallest full scale, top gain
                mx = 16'h7FFF; mn = 16'h0000; dv = 16'h0001;
                gp = 16'h7FFF; gq = 16'h0000; gd = 16'h0000; gg = 16'h0000;
            end
            2: begin    // zero full scale (taken as one), most negative gains
                mx = 16'd1500; mn = 16'd900; dv = 16'h0000;
                gp = 16'h8000; gq = 16'h8000; gd = 16'h8000; gg = 16'h8000;
            end
            3: begin    // min above max, largest full scale, top gains
                mx = 16'd800; mn = 16'd1200; dv = 16'h7FFF;
                gp = 16'd256; gq = 16'h7FFF; gd = 16'h7FFF; gg = 16'h7FFF;
            end
            4: begin    // bit 15 set on the 15-bit registers, to be dropped
                mx = 16'hFFFF; mn = 16'h8000 | 16'd300; dv = 16'hC000 | 16'd512;
            end
            7: begin    // every bit of every register at random
                mx = CFG_DATA_W'($urandom); mn = CFG_DATA_W'($urandom);
                dv = CFG_DATA_W'($urandom); gp = CFG_DATA_W'($urandom);
                gq = CFG_DATA_W'($urandom); gd = CFG_DATA_W'($urandom);
                gg = CFG_DATA_W'($urandom);
            end
            9: begin    // back to the power-on set
                mx = CFG_DATA_W'(MAX_SPEED_RST); mn = CFG_DATA_W'(MIN_SPEED_RST);
                dv = CFG_DATA_W'(MAX_DEV_RST);   gp = GAIN_P_RST;
                gq = GAIN_P_SQ_RST; gd = GAIN_D_RST; gg = GAIN_GYRO_RST;
            end
            default: ;
        endcase
        put_reg(REG_MAX_SPEED, mx);
        put_reg(REG_MIN_SPEED, mn);
        put_reg(REG_MAX_DEV,   dv);
        put_reg(REG_GAIN_P,    gp);
        put_reg(REG_GAIN_P_SQ, gq);
        put_reg(REG_GAIN_D,    gd);
        put_reg(REG_GAIN_GYRO, gg);
        cfg_we <= 1'b0;
    endtask

    // Result side: random back-pressure, a long hold-off when asked, and no
    // stalls at all while the steady phase runs.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result watcher: oldest prediction against each result taken.
    always @(posedge aclk) begin : watch_results
        drive_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.left_drv   = m_tdata[M_LEFT_LSB   +: DRIVE_W];
            got.right_drv  = m_tdata[M_RIGHT_LSB  +: DRIVE_W];
            got.tgt_speed  = m_tdata[M_TARGET_LSB +: SPEED_W];
            got.steer_corr = m_tdata[M_CORR_LSB   +: CORR_W];
            if (pending_drives.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none pending",
                                          results_seen));
            end else begin
                want = pending_drives.pop_front();
                if (got.left_drv !== want.left_drv)
                    report_mismatch($sformatf("result %0d left_drive %0d, want %0d",
                        results_seen, $signed(got.left_drv), $signed(want.left_drv)));
                if (got.right_drv !== want.right_drv)
                    report_mismatch($sformatf("result %0d right_drive %0d, want %0d",
                        results_seen, $signed(got.right_drv), $signed(want.right_drv)));
                if (got.tgt_speed !== want.tgt_speed)
                    report_mismatch($sformatf("result %0d target_speed %0d, want %0d",
                        results_seen, got.tgt_speed, want.tgt_speed));
                if (got.steer_corr !== want.steer_corr)
                    report_mismatch($sformatf("result %0d steer_correction %0d, want %0d",
                        results_seen, $signed(got.steer_corr), $signed(want.steer_corr)));
            end
            results_seen++;
        end
    end

    // Driver: reset, directed table, then the random phases.
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_MAX_SPEED;
        cfg_wdata <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i])
            offer_item(DIRECTED[i].stim, DIRECTED[i].known, DIRECTED[i].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                // registers only change with the block empty
                s_tvalid <= 1'b0;
                wait_drained();
                load_settings(ph);
            end
            steady_flow <= (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == 10)
                    holds_asked <= holds_asked + 1;   // receiver stalls, input backs up
                if (ph == 6 && n == 50) begin
                    s_tvalid <= 1'b0;                 // sender waits for a clean pipe
                    wait_drained();
                end
                offer_item(random_item(), 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("line_follow_steer_speed_control verification clean");
        end else begin
            $display("line_follow_steer_speed_control verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lfssc_pkg.sv
hw/rtl/lfssc_div.sv
hw/rtl/line_follow_steer_speed_control.sv
hw/rtl/lfssc_checker.sv
test/tb.sv
